// ----- rtl/wfba_pkg.sv -----
// Shared types and codes for the worst-fit block allocator.
package wfba_pkg;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TOO_BIG = 2'd1,
		ST_NO_MEM  = 2'd2,
		ST_UNKNOWN = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FSCAN,
		S_LSCAN,
		S_LREAD,
		S_DECIDE,
		S_COMMIT,
		S_OUT
	} state_t;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	// page geometry; block sizes travel in 12-bit fields
	localparam int PAGE_BYTES   = 4096;
	localparam int HEADER_BYTES = 16;

endpackage

// ----- rtl/worst_fit_block_allocator.sv -----
// Top level of the worst-fit block allocator: sequencer, tables and stream ports.
//
// Usage:
//   s_axis carries one item: tuser = kind (0 allocate, 1 free), tdata = request_size in
//   bits [11:0], block_address in bits [31:12]. m_axis returns one result per item:
//   tdata = payload_address [19:0], status [21:20], zero padded to 24 bits.
//   Status: 0 ok, 1 request too large, 2 out of memory or table full, 3 unknown free.
// Sequencing:
//   One item at a time. An item walks the free table (one entry per cycle through a
//   single size/stamp comparator, which also finds the lowest empty free slot) and
//   the live table (one entry per cycle, finding the lowest empty live slot and the
//   matching live block). Then come a read state, a decide state, a write state and
//   an output state. The next item is taken only once the sequencer is back in idle
//   after the output state; the two table walks take most of the time per item.
// Reset:
//   arst_n clears valid bits, page counter, stamp counter and the sequencer. Table
//   payload is never cleared; only valid entries are read.
// Stall:
//   The result waits in an output register until m_axis_tready. A new item may be
//   accepted meanwhile; it walks the tables and then holds in the output cycle, with
//   s_axis_tready low, until the register is free.
module worst_fit_block_allocator #(
	parameter int FREE_ENTRIES = 64,
	parameter int LIVE_ENTRIES = 128,
	parameter int MAX_PAGES    = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // request_size [11:0], block_address [31:12]
	input  logic        s_axis_tuser,   // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // payload_address [19:0], status [21:20]
);

	localparam int FW = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
	localparam int LW = (LIVE_ENTRIES > 1) ? $clog2(LIVE_ENTRIES) : 1;
	localparam int PW = $clog2(MAX_PAGES + 1);
	localparam logic [12:0] REQ_LIMIT  = 13'(wfba_pkg::PAGE_BYTES - wfba_pkg::HEADER_BYTES);
	localparam logic [12:0] HDR        = 13'(wfba_pkg::HEADER_BYTES);
	localparam logic [11:0] PAGE_PAY   = 12'(wfba_pkg::PAGE_BYTES - wfba_pkg::HEADER_BYTES);
	localparam int PSH = $clog2(wfba_pkg::PAGE_BYTES);

	wfba_pkg::state_t state_q, state_d;

	// tables
	logic [19:0] free_addr_mem [FREE_ENTRIES];
	logic [11:0] free_size_mem [FREE_ENTRIES];
	logic [31:0] free_stamp_mem [FREE_ENTRIES];
	logic [FREE_ENTRIES-1:0] free_valid_q;
	logic [19:0] live_addr_mem [LIVE_ENTRIES];
	logic [11:0] live_size_mem [LIVE_ENTRIES];
	logic [LIVE_ENTRIES-1:0] live_valid_q;
	logic [PW-1:0] pages_used_q;
	logic [31:0] insert_counter_q;

	// item
	logic        kind_q;
	logic [11:0] req_q;
	logic [19:0] addr_q;

	// scan state
	logic [FW-1:0] fidx_q;
	logic [LW-1:0] lidx_q;
	logic          best_ok_q;
	logic [FW-1:0] best_q;
	logic [11:0]   best_size_q;
	logic [31:0]   best_stamp_q;
	logic [19:0]   best_addr_q;
	logic          fempty_ok_q;
	logic [FW-1:0] fempty_q;
	logic          lempty_ok_q;
	logic [LW-1:0] lempty_q;
	logic          hit_ok_q;
	logic [LW-1:0] hit_q;
	logic [19:0]   hit_addr_q;
	logic [11:0]   hit_size_q;

	// registered memory reads
	logic [19:0] fa_rd_q;
	logic [11:0] fs_rd_q;
	logic [31:0] ft_rd_q;
	logic [19:0] la_rd_q;

	// decision
	logic [1:0]    st_q;
	logic [19:0]   pay_q;
	logic          do_write_q;
	logic          fw_en_q;
	logic [FW-1:0] fw_slot_q;
	logic [19:0]   fw_addr_q;
	logic [11:0]   fw_size_q;
	logic          take_page_q;
	logic          clr_best_q;
	logic          lw_en_q;
	logic [19:0]   lw_addr_q;
	logic [11:0]   lw_size_q;
	logic          clr_hit_q;

	logic          out_valid_q;
	logic [19:0]   out_addr_q;
	logic [1:0]    out_st_q;

	assign s_axis_tready = (state_q == wfba_pkg::S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_st_q, out_addr_q};

	wire in_acc  = s_axis_tvalid && s_axis_tready;
	wire out_acc = out_valid_q && m_axis_tready;
	// output register is free this cycle: load the finished item
	wire out_load = (state_q == wfba_pkg::S_OUT) && (!out_valid_q || out_acc);

	// read pipes: scan index -> registered data in the next cycle
	logic          fscan_s1, lscan_s1;
	logic [FW-1:0] fidx_s1;
	logic [LW-1:0] lidx_s1;
	logic          fvalid_s1, lvalid_s1;

	always_ff @(posedge clk) begin
		fa_rd_q <= free_addr_mem[fidx_q];
		fs_rd_q <= free_size_mem[fidx_q];
		ft_rd_q <= free_stamp_mem[fidx_q];
		la_rd_q <= live_addr_mem[lidx_q];
		if (fw_en_q && do_write_q) begin
			free_addr_mem[fw_slot_q]  <= fw_addr_q;
			// on a free the size comes from the live entry that was hit
			free_size_mem[fw_slot_q]  <= (kind_q == wfba_pkg::KIND_FREE) ? hit_size_q
				: fw_size_q;
			free_stamp_mem[fw_slot_q] <= insert_counter_q;
		end
		if (lw_en_q && do_write_q) begin
			live_addr_mem[lempty_q] <= lw_addr_q;
			live_size_mem[lempty_q] <= lw_size_q;
		end
	end

	always_ff @(posedge clk) begin
		hit_size_q <= live_size_mem[hit_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wfba_pkg::S_IDLE;
			free_valid_q <= '0;
			live_valid_q <= '0;
			pages_used_q <= '0;
			insert_counter_q <= '0;
			out_valid_q <= 1'b0;
			fscan_s1 <= 1'b0;
			lscan_s1 <= 1'b0;
			do_write_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fscan_s1 <= (state_q == wfba_pkg::S_FSCAN);
			lscan_s1 <= (state_q == wfba_pkg::S_LSCAN);
			if (out_load) out_valid_q <= 1'b1;
			else if (out_acc) out_valid_q <= 1'b0;
			do_write_q <= (state_q == wfba_pkg::S_DECIDE);
			if (state_q == wfba_pkg::S_COMMIT) begin
				if (fw_en_q) begin
					free_valid_q[fw_slot_q] <= 1'b1;
					insert_counter_q <= insert_counter_q + 32'd1;
				end
				if (clr_best_q && !(fw_en_q && fw_slot_q == best_q))
					free_valid_q[best_q] <= 1'b0;
				if (take_page_q) pages_used_q <= pages_used_q + PW'(1);
				if (lw_en_q) live_valid_q[lempty_q] <= 1'b1;
				if (clr_hit_q) live_valid_q[hit_q] <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		fidx_s1 <= fidx_q;
		lidx_s1 <= lidx_q;
		fvalid_s1 <= free_valid_q[fidx_q];
		lvalid_s1 <= live_valid_q[lidx_q];
		if (in_acc) begin
			kind_q <= s_axis_tuser;
			req_q  <= s_axis_tdata[11:0];
			addr_q <= s_axis_tdata[31:12];
			fidx_q <= '0;
			lidx_q <= '0;
			best_ok_q <= 1'b0;
			fempty_ok_q <= 1'b0;
			lempty_ok_q <= 1'b0;
			hit_ok_q <= 1'b0;
		end
		if (state_q == wfba_pkg::S_FSCAN) fidx_q <= fidx_q + FW'(1);
		if (state_q == wfba_pkg::S_LSCAN) lidx_q <= lidx_q + LW'(1);
		// shared compare unit on the free table
		if (fscan_s1) begin
			if (!fvalid_s1) begin
				if (!fempty_ok_q) begin
					fempty_ok_q <= 1'b1;
					fempty_q <= fidx_s1;
				end
			end else if (fs_rd_q > req_q &&
				(!best_ok_q || fs_rd_q > best_size_q ||
				(fs_rd_q == best_size_q && ft_rd_q > best_stamp_q))) begin
				best_ok_q <= 1'b1;
				best_q <= fidx_s1;
				best_size_q <= fs_rd_q;
				best_stamp_q <= ft_rd_q;
				best_addr_q <= fa_rd_q;
			end
		end
		if (lscan_s1) begin
			if (!lvalid_s1) begin
				if (!lempty_ok_q) begin
					lempty_ok_q <= 1'b1;
					lempty_q <= lidx_s1;
				end
			end else if (la_rd_q == addr_q && !hit_ok_q) begin
				hit_ok_q <= 1'b1;
				hit_q <= lidx_s1;
				hit_addr_q <= la_rd_q;
			end
		end
		if (state_q == wfba_pkg::S_DECIDE) begin : dec
			logic [19:0] base;
			logic [11:0] bsz;
			logic [12:0] rem;
			logic split;
			logic [1:0] st;
			logic [19:0] pay;
			logic fw_en, lw_en, take, clr_b, clr_h;
			base = best_ok_q ? best_addr_q
				: 20'((32'(pages_used_q) << PSH) + 32'(wfba_pkg::HEADER_BYTES));
			bsz = best_ok_q ? best_size_q : PAGE_PAY;
			rem = {1'b0, bsz} - {1'b0, req_q};
			split = rem > HDR;
			st = wfba_pkg::ST_OK;
			pay = '0;
			fw_en = 1'b0;
			lw_en = 1'b0;
			take = 1'b0;
			clr_b = 1'b0;
			clr_h = 1'b0;
			if (kind_q == wfba_pkg::KIND_ALLOC) begin
				if ({1'b0, req_q} + HDR >= REQ_LIMIT + HDR) st = wfba_pkg::ST_TOO_BIG;
				else if (!lempty_ok_q) st = wfba_pkg::ST_NO_MEM;
				else if (!best_ok_q && 32'(pages_used_q) >= 32'(MAX_PAGES))
					st = wfba_pkg::ST_NO_MEM;
				else if (split && !best_ok_q && !fempty_ok_q) st = wfba_pkg::ST_NO_MEM;
				else begin
					pay = base;
					lw_en = 1'b1;
					clr_b = best_ok_q;
					take = !best_ok_q;
					fw_en = split;
					lw_addr_q <= base;
					lw_size_q <= split ? req_q : bsz;
					fw_slot_q <= best_ok_q ? best_q : fempty_q;
					fw_addr_q <= base + 20'(req_q) + 20'(wfba_pkg::HEADER_BYTES);
					fw_size_q <= 12'(rem - HDR);
				end
			end else begin
				if (!hit_ok_q) st = wfba_pkg::ST_UNKNOWN;
				else if (!fempty_ok_q) st = wfba_pkg::ST_NO_MEM;
				else begin
					fw_en = 1'b1;
					clr_h = 1'b1;
					fw_slot_q <= fempty_q;
					fw_addr_q <= hit_addr_q;
				end
			end
			st_q <= st;
			pay_q <= pay;
			fw_en_q <= fw_en;
			lw_en_q <= lw_en;
			take_page_q <= take;
			clr_best_q <= clr_b;
			clr_hit_q <= clr_h;
		end
		if (out_load) begin
			out_addr_q <= pay_q;
			out_st_q <= st_q;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wfba_pkg::S_IDLE:   if (in_acc) state_d = wfba_pkg::S_FSCAN;
			wfba_pkg::S_FSCAN:
				if (fidx_q == FW'(FREE_ENTRIES - 1)) state_d = wfba_pkg::S_LSCAN;
			wfba_pkg::S_LSCAN:
				if (lidx_q == LW'(LIVE_ENTRIES - 1)) state_d = wfba_pkg::S_LREAD;
			wfba_pkg::S_LREAD:  state_d = wfba_pkg::S_DECIDE;
			wfba_pkg::S_DECIDE: state_d = wfba_pkg::S_COMMIT;
			wfba_pkg::S_COMMIT: state_d = wfba_pkg::S_OUT;
			wfba_pkg::S_OUT:
				if (out_load) state_d = wfba_pkg::S_IDLE;
			default:            state_d = wfba_pkg::S_IDLE;
		endcase
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != wfba_pkg::S_IDLE) |-> !s_axis_tready)
		else $error("accept while busy");
	a_pages_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pages_used_q) <= 32'(MAX_PAGES))
		else $error("page counter overrun");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(m_axis_tdata)))
		else $error("result dropped");

endmodule
